// ===== rtl/fbv_pkg.sv =====
// Shared types, constants and plane decoding for the frustum bounding-volume test.
// Depends on nothing; every other file imports it.
`default_nettype none
package fbv_pkg;

  localparam int CW        = 16;
  localparam int NW        = 16;
  localparam int NFRAC     = NW - 2;
  localparam int NPL       = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 64;
  localparam int PW        = 2 * CW;
  localparam int EW        = PW + 3;
  localparam int MW        = EW + NW;
  localparam int SH        = 2 * NFRAC;
  localparam int VW        = MW + 1;

  localparam logic [CFG_IDX_W-1:0] PL_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] PL_RIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] PL_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] PL_BOTTOM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] PL_NEAR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] PL_FAR    = 3'd5;

  localparam logic [1:0] OP_SPHERE = 2'd0;
  localparam logic [1:0] OP_TOUCH  = 2'd1;
  localparam logic [1:0] OP_BOX    = 2'd2;
  localparam logic [1:0] OP_POINT  = 2'd3;

  localparam logic [1:0] CLS_OUTSIDE = 2'd0;
  localparam logic [1:0] CLS_INTER   = 2'd1;
  localparam logic [1:0] CLS_INSIDE  = 2'd2;

  localparam logic [CFG_W-1:0] RST_LEFT   = 64'd16384;
  localparam logic [CFG_W-1:0] RST_RIGHT  = 64'd49152;
  localparam logic [CFG_W-1:0] RST_TOP    = 64'd3221225472;
  localparam logic [CFG_W-1:0] RST_BOTTOM = 64'd1073741824;
  localparam logic [CFG_W-1:0] RST_NEAR   = 64'd70368744177664;
  localparam logic [CFG_W-1:0] RST_FAR    = 64'd211106232532992;

  typedef logic signed [NW-1:0] norm_t;
  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    norm_t [2:0] n;
    logic [15:0] d;
  } plane_t;

  typedef struct packed {
    logic [1:0]    op;
    coord_t [2:0]  c;
    logic [CW-2:0] radius;
    coord_t [2:0]  q;
    logic [1:0]    cls;
    logic          hit;
  } item_t;

  function automatic plane_t decode_plane(input logic [CFG_W-1:0] r);
    plane_t p;
    p.n[0] = r[NW-1:0];
    p.n[1] = r[16+NW-1:16];
    p.n[2] = r[32+NW-1:32];
    p.d    = r[63:48];
    return p;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/fbv_classify.sv =====
// Three-stage front end: plane distances of the centre for all six planes at once,
// giving the sphere class, box hit and point hit. Depends on fbv_pkg.
`default_nettype none
module fbv_classify import fbv_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire plane_t        planes [NPL],
  input  wire logic          in_valid,
  input  wire item_t         in_item,
  input  wire logic [CW-2:0] half_x,
  input  wire logic [CW-2:0] half_y,
  input  wire logic [CW-2:0] half_z,
  output logic               out_valid,
  output item_t              out_item
);

  logic               v1_r, v2_r, v3_r;
  item_t              it1_r, it2_r, it3_r;
  logic signed [PW-1:0] p1_r [NPL][3];
  logic signed [EW-1:0] s2_r [NPL];
  logic [EW-1:0]      reach2_r [NPL];
  logic signed [EW-1:0] s2_nxt [NPL];
  logic [EW-1:0]      reach2_nxt [NPL];
  item_t              it3_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it1_r <= in_item;
      it2_r <= it1_r;
      it3_r <= it3_nxt;
      for (int i = 0; i < NPL; i++) begin
        for (int k = 0; k < 3; k++) begin
          p1_r[i][k] <= $signed(planes[i].n[k]) * $signed(in_item.c[k]);
        end
      end
      for (int i = 0; i < NPL; i++) begin
        s2_r[i]     <= s2_nxt[i];
        reach2_r[i] <= reach2_nxt[i];
      end
    end
  end

  logic [NW-1:0] absn [NPL][3];
  logic [PW-1:0] hm1_r [NPL][3];

  always_comb begin
    for (int i = 0; i < NPL; i++) begin
      for (int k = 0; k < 3; k++) begin
        absn[i][k] = planes[i].n[k][NW-1] ? NW'(-planes[i].n[k]) : NW'(planes[i].n[k]);
      end
    end
  end

  logic [CW-2:0] half_in [3];
  assign half_in[0] = half_x;
  assign half_in[1] = half_y;
  assign half_in[2] = half_z;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NPL; i++)
        for (int k = 0; k < 3; k++)
          hm1_r[i][k] <= PW'(absn[i][k]) * PW'(half_in[k]);
    end
  end

  always_comb begin
    for (int i = 0; i < NPL; i++) begin
      s2_nxt[i] = EW'(p1_r[i][0]) + EW'(p1_r[i][1]) + EW'(p1_r[i][2])
                - (EW'($signed(planes[i].d)) <<< NFRAC);
      reach2_nxt[i] = EW'(hm1_r[i][0]) + EW'(hm1_r[i][1]) + EW'(hm1_r[i][2]);
    end
  end

  logic signed [EW-1:0] rs;
  logic outside, inter, box_miss, pt_miss;

  always_comb begin
    rs       = EW'(it2_r.radius) <<< NFRAC;
    outside  = 1'b0;
    inter    = 1'b0;
    box_miss = 1'b0;
    pt_miss  = 1'b0;
    for (int i = 0; i < NPL; i++) begin
      if (s2_r[i] < -rs) outside = 1'b1;
      else if (s2_r[i] < rs) inter = 1'b1;
      if (-s2_r[i] > $signed(reach2_r[i])) box_miss = 1'b1;
      if (s2_r[i] < 0) pt_miss = 1'b1;
    end
    it3_nxt     = it2_r;
    it3_nxt.cls = CLS_OUTSIDE;
    it3_nxt.hit = 1'b0;
    case (it2_r.op)
      OP_SPHERE: it3_nxt.cls = outside ? CLS_OUTSIDE : (inter ? CLS_INTER : CLS_INSIDE);
      OP_BOX:    it3_nxt.hit = !box_miss;
      OP_POINT:  it3_nxt.hit = !pt_miss;
      default:   it3_nxt.hit = 1'b0;
    endcase
  end

  assign out_valid = v3_r;
  assign out_item  = it3_r;

endmodule
`default_nettype wire

// ===== rtl/fbv_plane_step.sv =====
// Four-stage projection of the working point onto one plane when it lies outside it:
// dot product, plane error, correction products, then round and saturate. Depends on fbv_pkg.
`default_nettype none
module fbv_plane_step import fbv_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   en,
  input  wire plane_t pl,
  input  wire logic   in_valid,
  input  wire item_t  in_item,
  output logic        out_valid,
  output item_t       out_item
);

  logic va_r, vb_r, vc_r, vd_r;
  item_t ita_r, itb_r, itc_r, itd_r, itd_nxt;
  logic signed [PW-1:0] pa_r [3];
  logic signed [EW-1:0] eb_r, eb_nxt;
  logic signed [MW-1:0] mc_r [3];
  logic negc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
    end
  end

  assign eb_nxt = EW'(pa_r[0]) + EW'(pa_r[1]) + EW'(pa_r[2])
                - (EW'($signed(pl.d)) <<< NFRAC);

  logic signed [VW-1:0] v [3];
  logic signed [VW-SH-1:0] sv [3];

  always_comb begin
    itd_nxt = itc_r;
    for (int k = 0; k < 3; k++) begin
      v[k]  = (VW'($signed(itc_r.q[k])) <<< SH) - VW'(mc_r[k]) + (VW'(1) <<< (SH - 1));
      sv[k] = v[k][VW-1:SH];
      if (negc_r) begin
        if (sv[k] > (VW-SH)'(32767)) itd_nxt.q[k] = {1'b0, {(CW-1){1'b1}}};
        else if (sv[k] < -(VW-SH)'(32768)) itd_nxt.q[k] = {1'b1, {(CW-1){1'b0}}};
        else itd_nxt.q[k] = sv[k][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ita_r <= in_item;
      itb_r <= ita_r;
      itc_r <= itb_r;
      itd_r <= itd_nxt;
      for (int k = 0; k < 3; k++) begin
        pa_r[k] <= $signed(pl.n[k]) * $signed(in_item.q[k]);
        mc_r[k] <= MW'($signed(pl.n[k])) * MW'(eb_r);
      end
      eb_r   <= eb_nxt;
      negc_r <= eb_r[EW-1];
    end
  end

  assign out_valid = vd_r;
  assign out_item  = itd_r;

endmodule
`default_nettype wire

// ===== rtl/fbv_touch_tail.sv =====
// Two-stage tail: squared distance from centre to closest point against radius squared,
// and final output formatting per op. Depends on fbv_pkg.
`default_nettype none
module fbv_touch_tail import fbv_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   en,
  input  wire logic   in_valid,
  input  wire item_t  in_item,
  output logic        out_valid,
  output item_t       out_item
);

  logic v1_r, v2_r;
  item_t it1_r, it2_r, it2_nxt;
  logic [PW-1:0] sq1_r [3];
  logic [PW-3:0] rr1_r;
  logic far1_r;
  logic signed [CW:0] df [3];
  logic [CW:0] adf [3];
  logic far_nxt;
  logic [PW+1:0] sum;

  always_comb begin
    far_nxt = 1'b0;
    for (int k = 0; k < 3; k++) begin
      df[k]  = (CW+1)'($signed(in_item.c[k])) - (CW+1)'($signed(in_item.q[k]));
      adf[k] = df[k][CW] ? (CW+1)'(-df[k]) : (CW+1)'(df[k]);
      if (adf[k] > (CW+1)'(32767)) far_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_comb begin
    sum = (PW+2)'(sq1_r[0]) + (PW+2)'(sq1_r[1]) + (PW+2)'(sq1_r[2]);
    it2_nxt = it1_r;
    if (it1_r.op == OP_TOUCH) begin
      it2_nxt.hit = !far1_r && (sum < (PW+2)'(rr1_r));
    end else begin
      it2_nxt.q = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it1_r  <= in_item;
      far1_r <= far_nxt;
      rr1_r  <= (PW-2)'(in_item.radius) * (PW-2)'(in_item.radius);
      for (int k = 0; k < 3; k++)
        sq1_r[k] <= PW'(adf[k][CW-1:0]) * PW'(adf[k][CW-1:0]);
      it2_r <= it2_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_item  = it2_r;

endmodule
`default_nettype wire

// ===== rtl/frustum_bounding_volume_test_core.sv =====
// Top level of the frustum bounding-volume test: plane registers, classify front end,
// six projection steps and the distance tail. Depends on fbv_pkg and all fbv_ modules.
//
//   Port group   Direction  Handshake           Payload
//   in_          input      in_valid/in_ready   op, center_x/y/z, radius, half_x/y/z
//   out_         output     out_valid/out_ready sphere_class, hit, closest_x/y/z
//   cfg_         input      cfg_we              cfg_index, cfg_data
//
// One word enters per cycle while the output is not stalled; the pipeline is the six serial
// plane projections of four stages each plus three front and two tail stages.
// Reset clears all valid bits and loads the default planes.
// The whole pipeline holds while out_valid is high and out_ready is low.
`default_nettype none
module frustum_bounding_volume_test_core import fbv_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [1:0]           in_op,
  input  wire logic signed [CW-1:0] in_center_x,
  input  wire logic signed [CW-1:0] in_center_y,
  input  wire logic signed [CW-1:0] in_center_z,
  input  wire logic [CW-2:0]        in_radius,
  input  wire logic [CW-2:0]        in_half_x,
  input  wire logic [CW-2:0]        in_half_y,
  input  wire logic [CW-2:0]        in_half_z,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [1:0]                out_sphere_class,
  output logic                      out_hit,
  output logic signed [CW-1:0]      out_closest_x,
  output logic signed [CW-1:0]      out_closest_y,
  output logic signed [CW-1:0]      out_closest_z,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  logic [CFG_W-1:0] plane_r [NPL];
  plane_t planes [NPL];
  logic en;
  item_t in_item, cls_item, tail_item;
  logic cls_valid, tail_valid;
  item_t st_item [NPL+1];
  logic st_valid [NPL+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r[PL_LEFT]   <= RST_LEFT;
      plane_r[PL_RIGHT]  <= RST_RIGHT;
      plane_r[PL_TOP]    <= RST_TOP;
      plane_r[PL_BOTTOM] <= RST_BOTTOM;
      plane_r[PL_NEAR]   <= RST_NEAR;
      plane_r[PL_FAR]    <= RST_FAR;
    end else if (cfg_we) begin
      case (cfg_index)
        PL_LEFT:   plane_r[PL_LEFT]   <= cfg_data;
        PL_RIGHT:  plane_r[PL_RIGHT]  <= cfg_data;
        PL_TOP:    plane_r[PL_TOP]    <= cfg_data;
        PL_BOTTOM: plane_r[PL_BOTTOM] <= cfg_data;
        PL_NEAR:   plane_r[PL_NEAR]   <= cfg_data;
        PL_FAR:    plane_r[PL_FAR]    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < NPL; i++) planes[i] = decode_plane(plane_r[i]);
  end

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_comb begin
    in_item        = '0;
    in_item.op     = in_op;
    in_item.c[0]   = in_center_x;
    in_item.c[1]   = in_center_y;
    in_item.c[2]   = in_center_z;
    in_item.radius = in_radius;
    in_item.q[0]   = in_center_x;
    in_item.q[1]   = in_center_y;
    in_item.q[2]   = in_center_z;
  end

  fbv_classify u_classify (
    .clk(clk), .rst_n(rst_n), .en(en), .planes(planes),
    .in_valid(in_valid && in_ready), .in_item(in_item),
    .half_x(in_half_x), .half_y(in_half_y), .half_z(in_half_z),
    .out_valid(cls_valid), .out_item(cls_item)
  );

  assign st_valid[0] = cls_valid;
  assign st_item[0]  = cls_item;

  localparam logic [CFG_IDX_W-1:0] ORDER [NPL] = '{PL_LEFT, PL_TOP, PL_RIGHT,
                                                   PL_BOTTOM, PL_NEAR, PL_FAR};

  for (genvar g = 0; g < NPL; g++) begin : g_step
    fbv_plane_step u_step (
      .clk(clk), .rst_n(rst_n), .en(en), .pl(planes[ORDER[g]]),
      .in_valid(st_valid[g]), .in_item(st_item[g]),
      .out_valid(st_valid[g+1]), .out_item(st_item[g+1])
    );
  end

  fbv_touch_tail u_tail (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(st_valid[NPL]), .in_item(st_item[NPL]),
    .out_valid(tail_valid), .out_item(tail_item)
  );

  assign out_valid        = tail_valid;
  assign out_sphere_class = tail_item.cls;
  assign out_hit          = tail_item.hit;
  assign out_closest_x    = tail_item.q[0];
  assign out_closest_y    = tail_item.q[1];
  assign out_closest_z    = tail_item.q[2];

`ifndef ASSERT_OFF
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow the output stall");
  a_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sphere_class != 2'd3)
    else $error("invalid sphere class");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_sphere_class != CLS_OUTSIDE) |-> !out_hit)
    else $error("sphere class and hit both set");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");
`endif

endmodule
`default_nettype wire
